[rtl/core/efrc_pkg.sv]
// Shared types, protocol constants and the CRC-8 byte update for the
// escaped frame receiver. No dependencies.

package efrc_pkg;

    // Framing bytes
    localparam logic [7:0] BYTE_ESC = 8'h50;
    localparam logic [7:0] BYTE_SOF = 8'h55;
    localparam logic [7:0] BYTE_EOF = 8'h5A;

    // Reflected CRC-8 polynomial and minimum good frame size
    localparam logic [7:0] CRC_POLY        = 8'h8C;
    localparam int unsigned MIN_FRAME_BYTES = 4;

    // Result kinds as they appear on the result channel
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_ABORT  = 2'd3
    } kind_t;

    // Receiver link mode
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_ESC   = 2'd2
    } mode_t;

    // Link state carried from byte to byte (the count is sized per instance)
    typedef struct packed {
        mode_t      mode;
        logic [7:0] crc;
    } link_t;

    // One result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [6:0] frame_length;
    } result_t;

    // Fold one byte into the reflected CRC-8, LSB first
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[rtl/core/efrc_rx_if.sv]
// Receive byte channel: valid/ready handshake with one raw serial byte.
// No dependencies.

interface efrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/efrc_res_if.sv]
// Result channel: valid/ready handshake carrying kind, payload byte and length.
// No dependencies.

interface efrc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [6:0] frame_length;

    modport source (output valid, output kind, output payload_byte, output frame_length,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input frame_length,
                    output ready);
endinterface

[rtl/core/efrc_decode.sv]
// Per-byte deframing logic: unescape, frame control, CRC update and result build.
// Depends on efrc_pkg.

module efrc_decode import efrc_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = 64,
    parameter int unsigned CNT_W           = 7
) (
    input  logic [7:0]       rx_byte,
    input  link_t            link,
    input  logic [CNT_W-1:0] count,
    output link_t            link_next,
    output logic [CNT_W-1:0] count_next,
    output logic             emit,
    output result_t          result
);

    logic [7:0] data_byte;
    logic       take_data;
    kind_t      kind;
    logic       frame_good;

    assign frame_good = (link.crc == 8'h00) && (count >= CNT_W'(MIN_FRAME_BYTES));

    always_comb
    begin
        link_next  = link;
        count_next = count;
        emit       = 1'b0;
        kind       = KIND_DATA;
        data_byte  = rx_byte;
        take_data  = 1'b0;

        // Decode the byte against the current mode
        unique case (link.mode)
            MODE_ESC:
            begin
                data_byte      = ~rx_byte;
                link_next.mode = MODE_FRAME;
                take_data      = 1'b1;
            end
            MODE_FRAME:
            begin
                priority if (rx_byte == BYTE_ESC)
                begin
                    link_next.mode = MODE_ESC;
                end
                else if (rx_byte == BYTE_SOF)
                begin
                    link_next.mode = MODE_IDLE;
                    emit           = 1'b1;
                    kind           = KIND_ABORT;
                end
                else if (rx_byte == BYTE_EOF)
                begin
                    link_next.mode = MODE_IDLE;
                    emit           = 1'b1;
                    kind           = frame_good ? KIND_ACCEPT : KIND_REJECT;
                end
                else
                begin
                    take_data = 1'b1;
                end
            end
            default:
            begin
                // Idle: only a start byte matters
                if (rx_byte == BYTE_SOF)
                begin
                    link_next.mode = MODE_FRAME;
                    link_next.crc  = 8'h00;
                    count_next     = '0;
                end
            end
        endcase

        // Store a data byte, or abort when the frame is full
        if (take_data)
        begin
            emit = 1'b1;
            if (count >= CNT_W'(MAX_FRAME_BYTES))
            begin
                link_next.mode = MODE_IDLE;
                kind           = KIND_ABORT;
            end
            else
            begin
                count_next    = count + CNT_W'(1);
                link_next.crc = crc_fold(link.crc, data_byte);
                kind          = KIND_DATA;
            end
        end
    end

    // Build the result item
    always_comb
    begin
        result.kind         = kind;
        result.payload_byte = (kind == KIND_DATA) ? data_byte : 8'h00;
        result.frame_length = 7'(count_next);
    end

endmodule

[rtl/core/escaped_frame_receiver_crc8_top.sv]
// Escaped frame receiver with CRC-8 check, top level.
// Depends on efrc_pkg, efrc_rx_if, efrc_res_if and efrc_decode.
//
// Usage:
//   rx  : sink of raw serial bytes (valid/ready, field rx_byte).
//   res : source of result items (kind, payload_byte, frame_length).
//   A frame opens with 0x55 and closes with 0x5A; 0x50 escapes the next byte,
//   which is taken complemented. Each payload byte is forwarded as kind 0;
//   the stop byte gives kind 1 (CRC residue zero, at least 4 bytes) or kind 2;
//   a start byte inside a frame or a byte beyond MAX_FRAME_BYTES gives kind 3.
//   Bytes outside a frame give no result.
// Timing:
//   A byte is captured in the input register on transfer; once the output
//   register is free or being emptied it goes through decode, and its result
//   is registered there. One byte is taken every cycle while res is not
//   stalled; the link state (mode, CRC, count) loops through the decode logic.
// Reset:
//   rst_n clears both registers' valid bits and returns the link to idle.
// Back-pressure:
//   While res is stalled the result and the input byte are held; rx.ready
//   drops only once both registers are occupied.

module escaped_frame_receiver_crc8_top import efrc_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    efrc_rx_if.sink   rx,
    efrc_res_if.source res
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_byte_reg;
    link_t            link_reg;
    link_t            link_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;

    logic             advance;
    logic             dec_emit;
    result_t          dec_result;

    // Move the held byte through decode when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    efrc_decode #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CNT_W           (CNT_W)
    ) u_decode (
        .rx_byte    (in_byte_reg),
        .link       (link_reg),
        .count      (count_reg),
        .link_next  (link_next),
        .count_next (count_next),
        .emit       (dec_emit),
        .result     (dec_result)
    );

    // Next valid flags for both registers
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx.valid && rx.ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = dec_emit;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            link_reg      <= '{mode: MODE_IDLE, crc: 8'h00};
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                link_reg  <= link_next;
                count_reg <= count_next;
            end
        end
    end

    // Capture payload: input byte on transfer, result on emit
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
        if (advance && dec_emit)
            out_reg <= dec_result;
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_reg.kind;
    assign res.payload_byte = out_reg.payload_byte;
    assign res.frame_length = out_reg.frame_length;

    // A decoded result always lands in the output register
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance && dec_emit |=> out_valid_reg)
        else $error("decoded result lost");

    // A byte that cannot advance stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input byte changed");

    // Byte count never passes the frame limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAME_BYTES))
        else $error("byte count above frame limit");

    // Only payload results carry a byte
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind != KIND_DATA |-> out_reg.payload_byte == 8'h00)
        else $error("non-data result carries a byte");

endmodule

[verif/tb_escaped_frame_receiver_crc8_top.sv]
// Self-checking testbench for escaped_frame_receiver_crc8_top: byte-stuffed frames
// with CRC-8 checks, random handshake gaps and a long result stall.
// Depends on efrc_pkg, efrc_rx_if, efrc_res_if and the receiver top level.
`timescale 1ns / 100ps

module tb_escaped_frame_receiver_crc8_top;
    import efrc_pkg::*;

    localparam int unsigned FRAME_LIMIT       = 64;
    localparam int          ITEM_TARGET       = 1250;
    localparam int          LONG_HOLD_CYCLES  = 300;
    localparam int          WATCHDOG_LIMIT    = 2000;
    localparam int          TAIL_CYCLES       = 10;
    localparam int          REPORT_LIMIT      = 10;
    localparam result_t     NO_RESULT         = '0;

    // How a stimulus row is checked
    typedef enum logic [1:0] {
        CHECK_PREDICTED = 2'd0,
        CHECK_NONE      = 2'd1,
        CHECK_TYPED     = 2'd2
    } check_t;

    typedef struct packed {
        logic [7:0] raw;
        check_t     check;
        result_t    res;
    } row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    efrc_rx_if  rx_ch ();
    efrc_res_if res_ch ();

    escaped_frame_receiver_crc8_top #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    // Predicted link state
    mode_t       rx_mode      = MODE_IDLE;
    logic [7:0]  crc_acc      = 8'h00;
    int unsigned stored_bytes = 0;

    result_t pending_results[$];
    int      error_count   = 0;
    int      framed_items  = 0;
    int      stall_cycles  = 0;
    bit      long_hold_req = 1'b0;
    bit      no_idle       = 1'b0;

    // Short directed sequence: noise, empty frame, escapes, abort, short and minimal frames
    row_t directed_rows [27] = '{
        '{8'h00,    CHECK_NONE,      NO_RESULT},
        '{8'hFF,    CHECK_NONE,      NO_RESULT},
        '{BYTE_EOF, CHECK_NONE,      NO_RESULT},
        '{BYTE_ESC, CHECK_NONE,      NO_RESULT},
        '{BYTE_SOF, CHECK_NONE,      NO_RESULT},
        '{BYTE_EOF, CHECK_TYPED,     '{KIND_REJECT, 8'h00, 7'd0}},
        '{BYTE_SOF, CHECK_NONE,      NO_RESULT},
        '{8'h00,    CHECK_TYPED,     '{KIND_DATA,   8'h00, 7'd1}},
        '{8'hFF,    CHECK_TYPED,     '{KIND_DATA,   8'hFF, 7'd2}},
        '{BYTE_ESC, CHECK_NONE,      NO_RESULT},
        '{BYTE_SOF, CHECK_TYPED,     '{KIND_DATA,   8'hAA, 7'd3}},
        '{BYTE_ESC, CHECK_NONE,      NO_RESULT},
        '{BYTE_EOF, CHECK_TYPED,     '{KIND_DATA,   8'hA5, 7'd4}},
        '{BYTE_ESC, CHECK_NONE,      NO_RESULT},
        '{BYTE_ESC, CHECK_TYPED,     '{KIND_DATA,   8'hAF, 7'd5}},
        '{BYTE_SOF, CHECK_TYPED,     '{KIND_ABORT,  8'h00, 7'd5}},
        '{BYTE_SOF, CHECK_NONE,      NO_RESULT},
        '{8'h00,    CHECK_PREDICTED, NO_RESULT},
        '{8'h00,    CHECK_PREDICTED, NO_RESULT},
        '{8'h00,    CHECK_PREDICTED, NO_RESULT},
        '{BYTE_EOF, CHECK_TYPED,     '{KIND_REJECT, 8'h00, 7'd3}},
        '{BYTE_SOF, CHECK_NONE,      NO_RESULT},
        '{8'h00,    CHECK_PREDICTED, NO_RESULT},
        '{8'h00,    CHECK_PREDICTED, NO_RESULT},
        '{8'h00,    CHECK_PREDICTED, NO_RESULT},
        '{8'h00,    CHECK_PREDICTED, NO_RESULT},
        '{BYTE_EOF, CHECK_TYPED,     '{KIND_ACCEPT, 8'h00, 7'd4}}
    };

    // Reflected CRC-8, one bit at a time, LSB first
    function automatic logic [7:0] crc8_maxim_next(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] acc;
        logic       fb;
        acc = c;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ d[i];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    // Advance the link state by one raw byte; return 1 when a result follows
    function automatic bit predict_frame_byte(input logic [7:0] raw, output result_t res,
                                              output bit ignored);
        logic [7:0] b;
        b       = raw;
        res     = NO_RESULT;
        ignored = 1'b0;
        case (rx_mode)
            MODE_ESC: begin
                b       = ~raw;
                rx_mode = MODE_FRAME;
            end
            MODE_FRAME: begin
                if (raw == BYTE_ESC) begin
                    rx_mode = MODE_ESC;
                    return 1'b0;
                end
                if (raw == BYTE_SOF) begin
                    rx_mode  = MODE_IDLE;
                    res.kind = KIND_ABORT;
                    res.frame_length = 7'(stored_bytes);
                    return 1'b1;
                end
                if (raw == BYTE_EOF) begin
                    rx_mode  = MODE_IDLE;
                    res.kind = (crc_acc == 8'h00 && stored_bytes >= MIN_FRAME_BYTES)
                               ? KIND_ACCEPT : KIND_REJECT;
                    res.frame_length = 7'(stored_bytes);
                    return 1'b1;
                end
            end
            default: begin
                // Outside a frame only a start byte matters
                if (raw == BYTE_SOF) begin
                    stored_bytes = 0;
                    crc_acc      = 8'h00;
                    rx_mode      = MODE_FRAME;
                end else begin
                    ignored = 1'b1;
                end
                return 1'b0;
            end
        endcase
        // Drop the frame once it is full
        if (stored_bytes >= FRAME_LIMIT) begin
            rx_mode  = MODE_IDLE;
            res.kind = KIND_ABORT;
            res.frame_length = 7'(stored_bytes);
            return 1'b1;
        end
        stored_bytes     = stored_bytes + 1;
        crc_acc          = crc8_maxim_next(crc_acc, b);
        res.kind         = KIND_DATA;
        res.payload_byte = b;
        res.frame_length = 7'(stored_bytes);
        return 1'b1;
    endfunction

    task automatic report_failure(input string what, input result_t want, input result_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s: expected kind %0d byte %02h len %0d, got kind %0d byte %02h len %0d",
                     $realtime, what, want.kind, want.payload_byte, want.frame_length,
                     got.kind, got.payload_byte, got.frame_length);
    endtask

    // Offer one raw byte, hold it until the transfer, then record what it should produce
    task automatic transfer_rx_byte(input logic [7:0] raw, input check_t check,
                                    input result_t typed);
        result_t predicted;
        bit      has_result;
        bit      ignored;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= raw;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        has_result = predict_frame_byte(raw, predicted, ignored);
        if (!ignored)
            framed_items++;
        if (check == CHECK_TYPED)
            pending_results.push_back(typed);
        else if (check == CHECK_PREDICTED && has_result)
            pending_results.push_back(predicted);
        // Idle the sender now and then, with junk on the data lines
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Send one payload byte, escaping it when it collides with a framing byte or at random
    task automatic send_payload_byte(input logic [7:0] d);
        if (d == BYTE_ESC || d == BYTE_SOF || d == BYTE_EOF || $urandom_range(0, 15) == 0) begin
            transfer_rx_byte(BYTE_ESC, CHECK_PREDICTED, NO_RESULT);
            transfer_rx_byte(~d, CHECK_PREDICTED, NO_RESULT);
        end else begin
            transfer_rx_byte(d, CHECK_PREDICTED, NO_RESULT);
        end
    endtask

    // One random frame: mostly well formed, sometimes corrupted, truncated or overlong
    task automatic send_frame();
        int         len;
        int         pick;
        int         ending;
        logic [7:0] d;
        logic [7:0] crc;
        crc  = 8'h00;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            len = $urandom_range(0, 8);
        else if (pick < 93)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(60, 66);
        // Line noise between frames
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3))
                transfer_rx_byte(8'($urandom_range(0, 255)), CHECK_PREDICTED, NO_RESULT);
        transfer_rx_byte(BYTE_SOF, CHECK_PREDICTED, NO_RESULT);
        for (int i = 0; i < len; i++) begin
            d   = 8'($urandom_range(0, 255));
            crc = crc8_maxim_next(crc, d);
            send_payload_byte(d);
        end
        ending = $urandom_range(0, 99);
        if (ending < 65) begin
            send_payload_byte(crc);
            transfer_rx_byte(BYTE_EOF, CHECK_PREDICTED, NO_RESULT);
        end else if (ending < 80) begin
            send_payload_byte(crc ^ 8'($urandom_range(1, 255)));
            transfer_rx_byte(BYTE_EOF, CHECK_PREDICTED, NO_RESULT);
        end else if (ending < 90) begin
            transfer_rx_byte(BYTE_EOF, CHECK_PREDICTED, NO_RESULT);
        end else if (ending < 95) begin
            transfer_rx_byte(BYTE_SOF, CHECK_PREDICTED, NO_RESULT);
        end
        // Otherwise leave the frame open; the next start byte aborts it
    endtask

    // Free-running clock
    initial begin
        forever #2 clk = ~clk;
    end

    // Stimulus
    initial begin : byte_source
        bit hold_done;
        bit pause_done;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            transfer_rx_byte(directed_rows[i].raw, directed_rows[i].check, directed_rows[i].res);

        while (framed_items < ITEM_TARGET) begin
            // Stall the result side for a long stretch while bytes keep coming
            if (!hold_done && framed_items >= 400) begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            // Pause the sender until every result has drained
            if (!pause_done && framed_items >= 750) begin
                rx_ch.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                pause_done = 1'b1;
            end
            if (framed_items >= ITEM_TARGET - 170)
                no_idle = 1'b1;
            send_frame();
        end

        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("escaped_frame_receiver_crc8_top verification clean");
        end else begin
            if (pending_results.size() != 0)
                $display("%0d results never arrived", pending_results.size());
            $display("escaped_frame_receiver_crc8_top verification failed");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int stall_len;
        int run_len;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                res_ch.ready <= 1'b0;
                stall_len = $urandom_range(1, 13);
                repeat (stall_len) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            run_len = $urandom_range(1, 24);
            repeat (run_len) begin
                @(posedge clk);
                if (long_hold_req)
                    break;
            end
        end
    end

    // Compare each result transfer with the oldest pending expectation
    always @(posedge clk) begin : result_check
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got.kind         = kind_t'(res_ch.kind);
            got.payload_byte = res_ch.payload_byte;
            got.frame_length = res_ch.frame_length;
            if (pending_results.size() == 0) begin
                report_failure("unexpected result", NO_RESULT, got);
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind || got.payload_byte != want.payload_byte
                        || got.frame_length != want.frame_length)
                    report_failure("result mismatch", want, got);
            end
        end
    end

    // End the run if neither side moves for too long
    always @(posedge clk) begin
        if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1)
                || (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", stall_cycles);
            $display("escaped_frame_receiver_crc8_top verification failed");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/core/efrc_pkg.sv
rtl/core/efrc_rx_if.sv
rtl/core/efrc_res_if.sv
rtl/core/efrc_decode.sv
rtl/core/escaped_frame_receiver_crc8_top.sv
verif/tb_escaped_frame_receiver_crc8_top.sv
